[sv/dhcp_reply_parser_assert.svh]
// Assertion macros for the DHCP reply parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef DHCP_REPLY_PARSER_ASSERT_SVH
`define DHCP_REPLY_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define DRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dhcp reply parser check failed");
// Next-cycle implication, disabled during reset
`define DRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dhcp reply parser check failed");
`else
`define DRP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DRP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/dhcprp_pkg.sv]
// Package for the DHCP reply parser: result type, option codes, slot decode.
// No dependencies.
`default_nettype none

package dhcprp_pkg;

    // Fixed packet layout
    localparam int unsigned OPTIONS_START = 240;
    localparam int unsigned ID_FIRST      = 4;
    localparam int unsigned ID_LAST       = 7;
    localparam int unsigned YIADDR_FIRST  = 16;
    localparam int unsigned YIADDR_LAST   = 19;
    localparam int unsigned SIADDR_FIRST  = 20;
    localparam int unsigned SIADDR_LAST   = 23;

    // Option codes
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_SUBNET    = 8'd1;
    localparam logic [7:0] OPT_ROUTER    = 8'd3;
    localparam logic [7:0] OPT_DNS       = 8'd6;
    localparam logic [7:0] OPT_BROADCAST = 8'd28;
    localparam logic [7:0] OPT_LEASE     = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_RENEW     = 8'd58;
    localparam logic [7:0] OPT_REBIND    = 8'd59;
    localparam logic [7:0] OPT_END       = 8'd255;

    // Message types and follow-up actions
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;
    localparam logic [7:0] MSG_NONE  = 8'd255;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_INSTALL = 2'd2;

    // Storage slots for 32-bit option words
    localparam int unsigned OPT_SLOTS = 7;
    localparam logic [3:0] SLOT_LEASE     = 4'd0;
    localparam logic [3:0] SLOT_RENEW     = 4'd1;
    localparam logic [3:0] SLOT_REBIND    = 4'd2;
    localparam logic [3:0] SLOT_SUBNET    = 4'd3;
    localparam logic [3:0] SLOT_ROUTER    = 4'd4;
    localparam logic [3:0] SLOT_DNS       = 4'd5;
    localparam logic [3:0] SLOT_BROADCAST = 4'd6;
    localparam logic [3:0] SLOT_TYPE      = 4'd7;
    localparam logic [3:0] SLOT_NONE      = 4'd8;

    typedef logic [31:0] t_word;

    // One parse result
    typedef struct packed {
        logic       id_match;
        logic [7:0] message_type;
        logic [1:0] next_action;
        t_word      offered_address;
        t_word      server_address;
        t_word      lease_time;
        t_word      renew_time;
        t_word      rebind_time;
        t_word      subnet_mask;
        t_word      router_address;
        t_word      dns_address;
        t_word      broadcast_address;
    } t_result;

    // Map an option code to its storage slot
    function automatic logic [3:0] slot_of(input logic [7:0] code);
        logic [3:0] slot;
        unique case (code)
            OPT_LEASE:     slot = SLOT_LEASE;
            OPT_RENEW:     slot = SLOT_RENEW;
            OPT_REBIND:    slot = SLOT_REBIND;
            OPT_SUBNET:    slot = SLOT_SUBNET;
            OPT_ROUTER:    slot = SLOT_ROUTER;
            OPT_DNS:       slot = SLOT_DNS;
            OPT_BROADCAST: slot = SLOT_BROADCAST;
            OPT_MSG_TYPE:  slot = SLOT_TYPE;
            default:       slot = SLOT_NONE;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

[sv/dhcprp_in_if.sv]
// Byte input channel of the DHCP reply parser.
// No dependencies.
`default_nettype none

interface dhcprp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[sv/dhcprp_cfg_if.sv]
// Configuration write channel: pending transaction id.
// No dependencies.
`default_nettype none

interface dhcprp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] pending_transaction;

    modport source (output valid, output pending_transaction, input ready);
    modport sink   (input valid, input pending_transaction, output ready);
endinterface

`default_nettype wire

[sv/dhcprp_out_if.sv]
// Result channel of the DHCP reply parser.
// No dependencies.
`default_nettype none

interface dhcprp_out_if;
    logic        valid;
    logic        ready;
    logic        id_match;
    logic [7:0]  message_type;
    logic [1:0]  next_action;
    logic [31:0] offered_address;
    logic [31:0] server_address;
    logic [31:0] lease_time;
    logic [31:0] renew_time;
    logic [31:0] rebind_time;
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] dns_address;
    logic [31:0] broadcast_address;

    modport source (
        output valid, output id_match, output message_type, output next_action,
        output offered_address, output server_address, output lease_time,
        output renew_time, output rebind_time, output subnet_mask,
        output router_address, output dns_address, output broadcast_address,
        input ready
    );
    modport sink (
        input valid, input id_match, input message_type, input next_action,
        input offered_address, input server_address, input lease_time,
        input renew_time, input rebind_time, input subnet_mask,
        input router_address, input dns_address, input broadcast_address,
        output ready
    );
endinterface

`default_nettype wire

[sv/dhcprp_core.sv]
// Per-byte parse state of the DHCP reply parser: header capture and option walk.
// Depends on dhcprp_pkg.
`default_nettype none

module dhcprp_core #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  wire  [7:0]              i_byte,
    input  wire                     i_last,
    input  wire  [31:0]             i_pending,
    output logic                    o_load,
    output dhcprp_pkg::t_result     o_result
);

    // Offset saturates at the packet limit; nothing past it matters
    localparam int unsigned OFF_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_PACKET_BYTES);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CODE,
        PH_LENGTH,
        PH_VALUE
    } t_phase;

    t_phase             r_phase, n_phase, ph_eff;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [7:0]         r_code, n_code;
    logic [7:0]         r_rem, n_rem;
    logic [2:0]         r_idx, n_idx;
    dhcprp_pkg::t_word  r_shift, n_shift;
    dhcprp_pkg::t_word  r_id, n_id;
    dhcprp_pkg::t_word  r_yiaddr, n_yiaddr;
    dhcprp_pkg::t_word  r_siaddr, n_siaddr;
    logic [7:0]         r_type, n_type;
    logic               r_ended, n_ended;
    dhcprp_pkg::t_word  r_words [dhcprp_pkg::OPT_SLOTS];
    dhcprp_pkg::t_word  n_words [dhcprp_pkg::OPT_SLOTS];
    logic               commit;
    logic [3:0]         slot;
    logic               match;

    // Next parse state for one byte
    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_code   = r_code;
        n_rem    = r_rem;
        n_idx    = r_idx;
        n_shift  = r_shift;
        n_id     = r_id;
        n_yiaddr = r_yiaddr;
        n_siaddr = r_siaddr;
        n_type   = r_type;
        n_ended  = r_ended;
        n_words  = r_words;
        commit   = 1'b0;
        slot     = dhcprp_pkg::slot_of(r_code);
        ph_eff   = r_phase;
        if (r_phase == PH_HEADER && r_off >= OFF_W'(dhcprp_pkg::OPTIONS_START)) begin
            ph_eff = PH_CODE;
        end
        if (i_step) begin
            if (!r_ended && r_off < OFF_MAX) begin
                n_phase = ph_eff;
                unique case (ph_eff)
                    PH_HEADER: begin
                        if (r_off >= OFF_W'(dhcprp_pkg::ID_FIRST) &&
                            r_off <= OFF_W'(dhcprp_pkg::ID_LAST)) begin
                            n_id = {r_id[23:0], i_byte};
                        end else if (r_off >= OFF_W'(dhcprp_pkg::YIADDR_FIRST) &&
                                     r_off <= OFF_W'(dhcprp_pkg::YIADDR_LAST)) begin
                            n_yiaddr = {r_yiaddr[23:0], i_byte};
                        end else if (r_off >= OFF_W'(dhcprp_pkg::SIADDR_FIRST) &&
                                     r_off <= OFF_W'(dhcprp_pkg::SIADDR_LAST)) begin
                            n_siaddr = {r_siaddr[23:0], i_byte};
                        end
                    end
                    PH_CODE: begin
                        if (i_byte == dhcprp_pkg::OPT_END) begin
                            n_ended = 1'b1;
                        end else if (i_byte != dhcprp_pkg::OPT_PAD) begin
                            n_code  = i_byte;
                            n_phase = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        n_rem   = i_byte;
                        n_idx   = 3'd0;
                        n_shift = '0;
                        if (i_byte == 8'd0) begin
                            commit  = 1'b1;
                            n_phase = PH_CODE;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        // Keep only the first four value bytes, left-aligned
                        if (!r_idx[2]) begin
                            n_shift[{~r_idx[1:0], 3'b000} +: 8] = i_byte;
                            n_idx  = r_idx + 3'd1;
                            commit = 1'b1;
                        end
                        n_rem = r_rem - 8'd1;
                        if (n_rem == 8'd0) begin
                            n_phase = PH_CODE;
                        end
                    end
                    default: n_phase = ph_eff;
                endcase
                // Store the value under way into its slot
                if (commit) begin
                    if (slot == dhcprp_pkg::SLOT_TYPE) begin
                        n_type = n_shift[31:24];
                    end else if (slot < dhcprp_pkg::SLOT_TYPE) begin
                        n_words[slot[2:0]] = n_shift;
                    end
                end
            end
            if (r_off != OFF_MAX) begin
                n_off = r_off + 1'b1;
            end
        end
    end

    // Result from the state after this byte
    assign match  = (n_id == i_pending);
    assign o_load = i_step && i_last;

    always_comb begin
        o_result.id_match          = match;
        o_result.message_type      = n_type;
        if (match && n_type == dhcprp_pkg::MSG_OFFER) begin
            o_result.next_action = dhcprp_pkg::ACT_REQUEST;
        end else if (match && n_type == dhcprp_pkg::MSG_ACK) begin
            o_result.next_action = dhcprp_pkg::ACT_INSTALL;
        end else begin
            o_result.next_action = dhcprp_pkg::ACT_NONE;
        end
        o_result.offered_address   = n_yiaddr;
        o_result.server_address    = n_siaddr;
        o_result.lease_time        = n_words[dhcprp_pkg::SLOT_LEASE[2:0]];
        o_result.renew_time        = n_words[dhcprp_pkg::SLOT_RENEW[2:0]];
        o_result.rebind_time       = n_words[dhcprp_pkg::SLOT_REBIND[2:0]];
        o_result.subnet_mask       = n_words[dhcprp_pkg::SLOT_SUBNET[2:0]];
        o_result.router_address    = n_words[dhcprp_pkg::SLOT_ROUTER[2:0]];
        o_result.dns_address       = n_words[dhcprp_pkg::SLOT_DNS[2:0]];
        o_result.broadcast_address = n_words[dhcprp_pkg::SLOT_BROADCAST[2:0]];
    end

    // Parse state; cleared by reset and after the last byte of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_load) begin
            r_phase  <= PH_HEADER;
            r_off    <= '0;
            r_code   <= '0;
            r_rem    <= '0;
            r_idx    <= '0;
            r_shift  <= '0;
            r_id     <= '0;
            r_yiaddr <= '0;
            r_siaddr <= '0;
            r_type   <= dhcprp_pkg::MSG_NONE;
            r_ended  <= 1'b0;
            for (int k = 0; k < dhcprp_pkg::OPT_SLOTS; k++) begin
                r_words[k] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_code   <= n_code;
            r_rem    <= n_rem;
            r_idx    <= n_idx;
            r_shift  <= n_shift;
            r_id     <= n_id;
            r_yiaddr <= n_yiaddr;
            r_siaddr <= n_siaddr;
            r_type   <= n_type;
            r_ended  <= n_ended;
            r_words  <= n_words;
        end
    end

endmodule

`default_nettype wire

[sv/dhcprp_out_reg.sv]
// Result register of the DHCP reply parser; holds one result until taken.
// Depends on dhcprp_pkg and dhcprp_out_if.
`default_nettype none

module dhcprp_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  dhcprp_pkg::t_result  i_result,
    output logic                 o_free,
    dhcprp_out_if.source         o_res
);

    logic                r_valid;
    dhcprp_pkg::t_result r_res;

    // Room for a new result this cycle
    assign o_free = !r_valid || o_res.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid             = r_valid;
    assign o_res.id_match          = r_res.id_match;
    assign o_res.message_type      = r_res.message_type;
    assign o_res.next_action       = r_res.next_action;
    assign o_res.offered_address   = r_res.offered_address;
    assign o_res.server_address    = r_res.server_address;
    assign o_res.lease_time        = r_res.lease_time;
    assign o_res.renew_time        = r_res.renew_time;
    assign o_res.rebind_time       = r_res.rebind_time;
    assign o_res.subnet_mask       = r_res.subnet_mask;
    assign o_res.router_address    = r_res.router_address;
    assign o_res.dns_address       = r_res.dns_address;
    assign o_res.broadcast_address = r_res.broadcast_address;

endmodule

`default_nettype wire

[sv/dhcp_reply_parser.sv]
// Top level of the DHCP reply parser: input register, config register, wiring.
// Depends on dhcprp_pkg, the channel interfaces, dhcprp_core, dhcprp_out_reg.
//
//   channel  dir  width  transaction
//   i_in     in   8+1    one payload byte, last_byte marks the packet end
//   i_cfg    in   32     pending transaction id write, always ready
//   o_res    out  299    one parse result per packet
//
// One byte per cycle unless a last byte waits on the result register; a byte
// passes the input register, then the parse logic feeding the result register.
// Reset clears the parse state; it is also cleared after each last byte.
// A stalled result holds only a last byte in the input register; other
// bytes keep flowing while the result waits.
`default_nettype none

`include "dhcp_reply_parser_assert.svh"

module dhcp_reply_parser #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dhcprp_in_if.sink    i_in,
    dhcprp_cfg_if.sink   i_cfg,
    dhcprp_out_if.source o_res
);

    logic                r_in_valid;
    logic [7:0]          r_byte;
    logic                r_last;
    logic [31:0]         r_pending;
    logic                advance;
    logic                out_free;
    logic                core_load;
    dhcprp_pkg::t_result core_result;
    logic                in_held;
    logic                res_acting;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_cfg.valid) begin
            r_pending <= i_cfg.pending_transaction;
        end
    end

    // Input register; only a last byte waits on the result register
    assign advance    = r_in_valid && (!r_last || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    dhcprp_core #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_byte),
        .i_last    (r_last),
        .i_pending (r_pending),
        .o_load    (core_load),
        .o_result  (core_result)
    );

    dhcprp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (core_load),
        .i_result (core_result),
        .o_free   (out_free),
        .o_res    (o_res)
    );

    // Checks
    assign in_held    = r_in_valid && !advance;
    assign res_acting = o_res.valid && (o_res.next_action != dhcprp_pkg::ACT_NONE);

    `DRP_ASSERT_IMP(a_load_room, i_clk, i_rst_n, core_load, out_free)
    `DRP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, in_held, r_in_valid && $stable({r_byte, r_last}))
    `DRP_ASSERT_NXT(a_out_set, i_clk, i_rst_n, core_load, o_res.valid)
    `DRP_ASSERT_IMP(a_action_match, i_clk, i_rst_n, res_acting, o_res.id_match)

endmodule

`default_nettype wire

[tb/dhcp_reply_parser_tb.sv]
// Self-checking testbench for dhcp_reply_parser: byte streams in, one parse reply per packet.
// Depends on dhcprp_pkg, the dhcprp_in_if, dhcprp_cfg_if and dhcprp_out_if channels,
// and the dhcp_reply_parser top level.
module dhcp_reply_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PACKET_LIMIT  = 2048;
    localparam int unsigned CYCLE_LIMIT   = 100_000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 6;

    // Packet lengths that stop inside the header fields
    localparam int unsigned SHORT_CUTS [4] = '{1, 6, 18, 22};

    typedef enum logic [1:0] {WALK_HEADER, WALK_CODE, WALK_LENGTH, WALK_VALUE} t_walk_phase;

    // Tracks the option walk of the current packet and holds the replies still owed
    class reply_tracker;
        dhcprp_pkg::t_word   pending_id;
        logic [15:0]         offset;
        t_walk_phase         phase;
        logic [7:0]          code;
        logic [7:0]          remaining;
        logic [7:0]          value_count;
        dhcprp_pkg::t_word   value_acc;
        dhcprp_pkg::t_word   xid_word;
        dhcprp_pkg::t_word   yiaddr_word;
        dhcprp_pkg::t_word   siaddr_word;
        logic [7:0]          type_byte;
        dhcprp_pkg::t_word   words [dhcprp_pkg::OPT_SLOTS];
        bit                  options_done;
        dhcprp_pkg::t_result expected_replies [$];
        int unsigned         mismatches;
        int unsigned         replies_checked;

        function new();
            pending_id = '0;
            clear_packet();
        endfunction

        function void clear_packet();
            offset       = '0;
            phase        = WALK_HEADER;
            code         = '0;
            remaining    = '0;
            value_count  = '0;
            value_acc    = '0;
            xid_word     = '0;
            yiaddr_word  = '0;
            siaddr_word  = '0;
            type_byte    = dhcprp_pkg::MSG_NONE;
            options_done = 1'b0;
            foreach (words[i]) words[i] = '0;
        endfunction

        // Commit the value gathered so far to the field of the current option
        function void store_value();
            case (code)
                dhcprp_pkg::OPT_LEASE:     words[dhcprp_pkg::SLOT_LEASE]     = value_acc;
                dhcprp_pkg::OPT_RENEW:     words[dhcprp_pkg::SLOT_RENEW]     = value_acc;
                dhcprp_pkg::OPT_REBIND:    words[dhcprp_pkg::SLOT_REBIND]    = value_acc;
                dhcprp_pkg::OPT_SUBNET:    words[dhcprp_pkg::SLOT_SUBNET]    = value_acc;
                dhcprp_pkg::OPT_ROUTER:    words[dhcprp_pkg::SLOT_ROUTER]    = value_acc;
                dhcprp_pkg::OPT_DNS:       words[dhcprp_pkg::SLOT_DNS]       = value_acc;
                dhcprp_pkg::OPT_BROADCAST: words[dhcprp_pkg::SLOT_BROADCAST] = value_acc;
                dhcprp_pkg::OPT_MSG_TYPE:  type_byte = value_acc[31:24];
                default: ;
            endcase
        endfunction

        // Header capture, then the code / length / value record walk
        function void walk_byte(logic [7:0] b);
            if (phase == WALK_HEADER && offset >= dhcprp_pkg::OPTIONS_START)
                phase = WALK_CODE;
            case (phase)
                WALK_HEADER: begin
                    if (offset >= dhcprp_pkg::ID_FIRST && offset <= dhcprp_pkg::ID_LAST)
                        xid_word = {xid_word[23:0], b};
                    else if (offset >= dhcprp_pkg::YIADDR_FIRST &&
                             offset <= dhcprp_pkg::YIADDR_LAST)
                        yiaddr_word = {yiaddr_word[23:0], b};
                    else if (offset >= dhcprp_pkg::SIADDR_FIRST &&
                             offset <= dhcprp_pkg::SIADDR_LAST)
                        siaddr_word = {siaddr_word[23:0], b};
                end
                WALK_CODE: begin
                    if (b == dhcprp_pkg::OPT_END) begin
                        options_done = 1'b1;
                    end else if (b != dhcprp_pkg::OPT_PAD) begin
                        code  = b;
                        phase = WALK_LENGTH;
                    end
                end
                WALK_LENGTH: begin
                    remaining   = b;
                    value_count = '0;
                    value_acc   = '0;
                    if (b == 8'd0) begin
                        store_value();
                        phase = WALK_CODE;
                    end else begin
                        phase = WALK_VALUE;
                    end
                end
                default: begin
                    // only the first four value bytes count, left-aligned
                    if (value_count < 4) begin
                        value_acc[8 * (3 - value_count) +: 8] = b;
                        value_count++;
                        store_value();
                    end
                    remaining--;
                    if (remaining == 8'd0)
                        phase = WALK_CODE;
                end
            endcase
        endfunction

        // Note one accepted byte; the last byte of a packet owes a reply
        function void take_byte(logic [7:0] b, logic last);
            dhcprp_pkg::t_result r;
            if (!options_done && offset < PACKET_LIMIT)
                walk_byte(b);
            if (offset != 16'hFFFF)
                offset++;
            if (last) begin
                r.id_match          = (xid_word == pending_id);
                r.message_type      = type_byte;
                r.next_action       = dhcprp_pkg::ACT_NONE;
                if (r.id_match && type_byte == dhcprp_pkg::MSG_OFFER)
                    r.next_action = dhcprp_pkg::ACT_REQUEST;
                else if (r.id_match && type_byte == dhcprp_pkg::MSG_ACK)
                    r.next_action = dhcprp_pkg::ACT_INSTALL;
                r.offered_address   = yiaddr_word;
                r.server_address    = siaddr_word;
                r.lease_time        = words[dhcprp_pkg::SLOT_LEASE];
                r.renew_time        = words[dhcprp_pkg::SLOT_RENEW];
                r.rebind_time       = words[dhcprp_pkg::SLOT_REBIND];
                r.subnet_mask       = words[dhcprp_pkg::SLOT_SUBNET];
                r.router_address    = words[dhcprp_pkg::SLOT_ROUTER];
                r.dns_address       = words[dhcprp_pkg::SLOT_DNS];
                r.broadcast_address = words[dhcprp_pkg::SLOT_BROADCAST];
                expected_replies.push_back(r);
                clear_packet();
            end
        endfunction

        function void check_field(string name, dhcprp_pkg::t_word want,
                                  dhcprp_pkg::t_word got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted reply with the oldest one owed
        function void compare_reply(dhcprp_pkg::t_result got);
            dhcprp_pkg::t_result want;
            if (expected_replies.size() == 0) begin
                $display("%0t: reply with none owed, expected nothing actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            replies_checked++;
            check_field("id_match", want.id_match, got.id_match);
            check_field("message_type", want.message_type, got.message_type);
            check_field("next_action", want.next_action, got.next_action);
            check_field("offered_address", want.offered_address, got.offered_address);
            check_field("server_address", want.server_address, got.server_address);
            check_field("lease_time", want.lease_time, got.lease_time);
            check_field("renew_time", want.renew_time, got.renew_time);
            check_field("rebind_time", want.rebind_time, got.rebind_time);
            check_field("subnet_mask", want.subnet_mask, got.subnet_mask);
            check_field("router_address", want.router_address, got.router_address);
            check_field("dns_address", want.dns_address, got.dns_address);
            check_field("broadcast_address", want.broadcast_address, got.broadcast_address);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dhcprp_in_if  in_ch ();
    dhcprp_cfg_if cfg_ch ();
    dhcprp_out_if res_ch ();

    reply_tracker tracker = new();

    bit          gaps_on;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned rx_stall;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned packets_sent;
    int unsigned id_writes;

    dhcp_reply_parser #(
        .MAX_PACKET_BYTES(PACKET_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, tracker.expected_replies.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Reply side: check each transaction, then pick ready for the next cycle
    always @(posedge i_clk) begin : reply_sink
        dhcprp_pkg::t_result got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    = 0;
            rx_stall     = 0;
        end else begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got.id_match          = res_ch.id_match;
                got.message_type      = res_ch.message_type;
                got.next_action       = res_ch.next_action;
                got.offered_address   = res_ch.offered_address;
                got.server_address    = res_ch.server_address;
                got.lease_time        = res_ch.lease_time;
                got.renew_time        = res_ch.renew_time;
                got.rebind_time       = res_ch.rebind_time;
                got.subnet_mask       = res_ch.subnet_mask;
                got.router_address    = res_ch.router_address;
                got.dns_address       = res_ch.dns_address;
                got.broadcast_address = res_ch.broadcast_address;
                tracker.compare_reply(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                res_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                rx_stall = $urandom_range(0, 11);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Fixed header: transaction id, offered and server address, random filler
    function automatic void put_header(ref logic [7:0] pkt [$],
                                       input dhcprp_pkg::t_word xid,
                                       input dhcprp_pkg::t_word yiaddr,
                                       input dhcprp_pkg::t_word siaddr);
        int unsigned i;
        pkt.delete();
        for (i = 0; i < dhcprp_pkg::OPTIONS_START; i++) begin
            if (i >= dhcprp_pkg::ID_FIRST && i <= dhcprp_pkg::ID_LAST)
                pkt.push_back(xid[8 * (dhcprp_pkg::ID_LAST - i) +: 8]);
            else if (i >= dhcprp_pkg::YIADDR_FIRST && i <= dhcprp_pkg::YIADDR_LAST)
                pkt.push_back(yiaddr[8 * (dhcprp_pkg::YIADDR_LAST - i) +: 8]);
            else if (i >= dhcprp_pkg::SIADDR_FIRST && i <= dhcprp_pkg::SIADDR_LAST)
                pkt.push_back(siaddr[8 * (dhcprp_pkg::SIADDR_LAST - i) +: 8]);
            else
                pkt.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_option(ref logic [7:0] pkt [$], input logic [7:0] c,
                                       input int unsigned len);
        pkt.push_back(c);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void add_word(ref logic [7:0] pkt [$], input logic [7:0] c,
                                     input dhcprp_pkg::t_word v);
        pkt.push_back(c);
        pkt.push_back(8'd4);
        for (int k = 3; k >= 0; k--) pkt.push_back(v[8 * k +: 8]);
    endfunction

    function automatic void add_type(ref logic [7:0] pkt [$], input logic [7:0] t);
        pkt.push_back(dhcprp_pkg::OPT_MSG_TYPE);
        pkt.push_back(8'd1);
        pkt.push_back(t);
    endfunction

    // One byte transaction, then maybe an idle burst
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.take_byte(b, last);
        bytes_sent++;
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_packet(ref logic [7:0] pkt [$]);
        for (int unsigned i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // Wait until every owed reply is in and the pipeline has emptied
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pending(input dhcprp_pkg::t_word id);
        cfg_ch.valid               <= 1'b1;
        cfg_ch.pending_transaction <= id;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        tracker.pending_id = id;
        id_writes++;
    endtask

    initial begin
        logic [7:0] pkt [$];
        in_ch.valid                = 1'b0;
        in_ch.data_byte            = 8'd0;
        in_ch.last_byte            = 1'b0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.pending_transaction = '0;
        res_ch.ready               = 1'b0;
        i_rst_n                    = 1'b0;
        gaps_on                    = 1'b0;
        hold_request               = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;

        // Offer under the reset pending id: every kept option, repeats (last wins),
        // zero, short and long values, a pad, an unknown code, a record after the end
        put_header(pkt, '0, $urandom, $urandom);
        add_type(pkt, dhcprp_pkg::MSG_OFFER);
        add_word(pkt, dhcprp_pkg::OPT_LEASE, 32'hFFFF_FFFF);
        add_option(pkt, dhcprp_pkg::OPT_LEASE, 0);
        add_option(pkt, dhcprp_pkg::OPT_RENEW, 1);
        add_option(pkt, dhcprp_pkg::OPT_REBIND, 2);
        add_option(pkt, dhcprp_pkg::OPT_SUBNET, 3);
        add_option(pkt, dhcprp_pkg::OPT_ROUTER, 6);
        add_word(pkt, dhcprp_pkg::OPT_DNS, 32'hFFFF_FFFF);
        add_word(pkt, dhcprp_pkg::OPT_BROADCAST, $urandom);
        pkt.push_back(dhcprp_pkg::OPT_PAD);
        add_option(pkt, 8'd200, 2);
        pkt.push_back(dhcprp_pkg::OPT_END);
        add_type(pkt, dhcprp_pkg::MSG_ACK);
        send_packet(pkt);

        settle();
        write_pending(32'hFFFF_FFFF);

        // Matched ack after a zero-length type; subnet record cut short by the last byte
        put_header(pkt, 32'hFFFF_FFFF, $urandom, $urandom);
        add_option(pkt, dhcprp_pkg::OPT_MSG_TYPE, 0);
        add_type(pkt, dhcprp_pkg::MSG_ACK);
        pkt.push_back(dhcprp_pkg::OPT_SUBNET);
        pkt.push_back(8'd4);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        send_packet(pkt);

        // Packets that end inside the header fields
        foreach (SHORT_CUTS[k]) begin
            put_header(pkt, 32'hFFFF_FFFF, $urandom, $urandom);
            while (pkt.size() > SHORT_CUTS[k]) void'(pkt.pop_back());
            send_packet(pkt);
        end

        // Back-pressure: replies held off while short packets keep coming
        settle();
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (20) begin
            pkt.delete();
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            send_packet(pkt);
        end

        // Closing stretch at full rate: short line noise
        repeat (4) begin
            pkt.delete();
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
            send_packet(pkt);
        end

        settle();
        $display("ran %0d packets (%0d bytes) under %0d pending ids; %0d replies checked",
                 packets_sent, bytes_sent, id_writes + 1, tracker.replies_checked);
        if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
